// ===== rtl/core/mwvw_pkg.sv =====
// shared widths, stage payload types and the quarter-wave sine rom contents
package mwvw_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int TABLE_N         = 1 << SINE_TABLE_BITS;
	localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;
	localparam int SINE_W          = 15;
	localparam int TRIG_W          = SINE_W + 1;

	localparam int VEL_W      = 16;
	localparam int HEADING_W  = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_INDEX_W = 8;
	localparam int PROD16_W   = 2 * VEL_W;
	localparam int ROT_W      = VEL_W + CFG_W + 1;
	localparam int BODY_W     = PROD16_W + 3;
	localparam int SUM_W      = BODY_W;
	localparam int PROD_W     = SUM_W + CFG_W + 1;
	localparam int WHEEL_W    = 24;
	localparam int ROUND_SHIFT = 24;
	localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);

	localparam logic [CFG_INDEX_W-1:0] REG_INV_RADIUS = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_LEVER_ARM  = CFG_INDEX_W'(1);

	localparam logic [CFG_W-1:0] INV_RADIUS_RESET = CFG_W'(5120);
	localparam logic [CFG_W-1:0] LEVER_ARM_RESET  = CFG_W'(14408);

	localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = {1'b0, {(WHEEL_W-1){1'b1}}};
	localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = {1'b1, {(WHEEL_W-1){1'b0}}};

	// taylor series of sine in unsigned q30, pi/2 in q30
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272};
	localparam longint SINE_ONE = 64'sd16384;

	typedef logic [SINE_W-1:0] sine_rom_t [TABLE_N+1];

	typedef struct packed {
		logic signed [VEL_W-1:0]  yaw;
		logic signed [VEL_W-1:0]  dx;
		logic signed [VEL_W-1:0]  dy;
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} trig_t;

	typedef struct packed {
		logic signed [BODY_W-1:0] vx;
		logic signed [BODY_W-1:0] vy;
		logic signed [ROT_W-1:0]  rot;
	} body_t;

	typedef struct packed {
		logic signed [WHEEL_W-1:0] fl;
		logic signed [WHEEL_W-1:0] fr;
		logic signed [WHEEL_W-1:0] rl;
		logic signed [WHEEL_W-1:0] rr;
	} wheels_t;

	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		x    = (longint'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if ((n % 2) == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		acc = (acc + 32768) >>> 16;
		if (acc > SINE_ONE) begin
			acc = SINE_ONE;
		end
		return acc[SINE_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k <= TABLE_N; k++) begin
			rom[k] = sine_entry(k);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/core/mwvw_trig.sv =====
// stage 1: heading quadrant split and registered sine and cosine rom reads
module mwvw_trig (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mwvw_pkg::VEL_W-1:0]   yaw_rate,
	input  logic signed [mwvw_pkg::VEL_W-1:0]   vel_x_world,
	input  logic signed [mwvw_pkg::VEL_W-1:0]   vel_y_world,
	input  logic [mwvw_pkg::HEADING_W-1:0]      heading,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mwvw_pkg::trig_t                     out_data
);
	import mwvw_pkg::*;

	logic                      valid_s1;
	logic signed [VEL_W-1:0]   yaw_s1;
	logic signed [VEL_W-1:0]   dx_s1;
	logic signed [VEL_W-1:0]   dy_s1;
	logic [SINE_W-1:0]         sin_mag_s1;
	logic [SINE_W-1:0]         cos_mag_s1;
	logic                      sin_neg_s1;
	logic                      cos_neg_s1;

	logic [1:0]                quad;
	logic [ROM_ADDR_W-1:0]     addr_up;
	logic [ROM_ADDR_W-1:0]     addr_down;
	logic [ROM_ADDR_W-1:0]     sin_addr;
	logic [ROM_ADDR_W-1:0]     cos_addr;
	logic                      en_s1;

	assign quad      = heading[HEADING_W-1 -: 2];
	assign addr_up   = {1'b0, heading[HEADING_W-3 -: SINE_TABLE_BITS]};
	assign addr_down = ROM_ADDR_W'(TABLE_N) - addr_up;
	// cosine sits one quadrant ahead, so odd quadrants swap the two addresses
	assign sin_addr  = quad[0] ? addr_down : addr_up;
	assign cos_addr  = quad[0] ? addr_up : addr_down;

	assign en_s1    = !valid_s1 || out_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			yaw_s1     <= yaw_rate;
			dx_s1      <= vel_x_world;
			dy_s1      <= vel_y_world;
			sin_mag_s1 <= SINE_ROM[sin_addr];
			cos_mag_s1 <= SINE_ROM[cos_addr];
			sin_neg_s1 <= quad[1];
			cos_neg_s1 <= quad[1] ^ quad[0];
		end
	end

	assign out_valid      = valid_s1;
	assign out_data.yaw   = yaw_s1;
	assign out_data.dx    = dx_s1;
	assign out_data.dy    = dy_s1;
	assign out_data.sin_v = sin_neg_s1 ? -$signed({1'b0, sin_mag_s1})
		: $signed({1'b0, sin_mag_s1});
	assign out_data.cos_v = cos_neg_s1 ? -$signed({1'b0, cos_mag_s1})
		: $signed({1'b0, cos_mag_s1});

endmodule

// ===== rtl/core/mwvw_rotate.sv =====
// stages 2 and 3: world to body rotation products and the yaw lever term
module mwvw_rotate (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mwvw_pkg::CFG_W-1:0]   lever_arm,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  mwvw_pkg::trig_t              in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output mwvw_pkg::body_t              out_data
);
	import mwvw_pkg::*;

	logic                       valid_s2;
	logic signed [PROD16_W-1:0] dxc_s2;
	logic signed [PROD16_W-1:0] dys_s2;
	logic signed [PROD16_W-1:0] dxs_s2;
	logic signed [PROD16_W-1:0] dyc_s2;
	logic signed [ROT_W-1:0]    rot_s2;

	logic                       valid_s3;
	logic signed [BODY_W-1:0]   vx_s3;
	logic signed [BODY_W-1:0]   vy_s3;
	logic signed [ROT_W-1:0]    rot_s3;

	logic en_s2;
	logic en_s3;

	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= in_valid;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dxc_s2 <= in_data.dx * in_data.cos_v;
			dys_s2 <= in_data.dy * in_data.sin_v;
			dxs_s2 <= in_data.dx * in_data.sin_v;
			dyc_s2 <= in_data.dy * in_data.cos_v;
			rot_s2 <= in_data.yaw * $signed({1'b0, lever_arm});
		end
	end

	// q.26 products lifted to q.28
	always_ff @(posedge clk) begin
		if (en_s3) begin
			vx_s3  <= (BODY_W'(dxc_s2) + BODY_W'(dys_s2)) <<< 2;
			vy_s3  <= (BODY_W'(dyc_s2) - BODY_W'(dxs_s2)) <<< 2;
			rot_s3 <= rot_s2;
		end
	end

	assign out_valid    = valid_s3;
	assign out_data.vx  = vx_s3;
	assign out_data.vy  = vy_s3;
	assign out_data.rot = rot_s3;

endmodule

// ===== rtl/core/mwvw_wheel.sv =====
// stages 4 to 6: wheel sums, inverse radius scaling, rounding and saturation
module mwvw_wheel (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mwvw_pkg::CFG_W-1:0]   inv_radius,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  mwvw_pkg::body_t              in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output mwvw_pkg::wheels_t            out_data
);
	import mwvw_pkg::*;

	logic                     valid_s4;
	logic signed [SUM_W-1:0]  sum_s4 [4];
	logic                     valid_s5;
	logic signed [PROD_W-1:0] prod_s5 [4];
	logic                     valid_s6;
	wheels_t                  wheels_s6;

	logic signed [SUM_W-1:0]  diff_v;
	logic signed [SUM_W-1:0]  plus_v;
	logic signed [SUM_W-1:0]  rot_v;
	logic en_s4;
	logic en_s5;
	logic en_s6;

	// floor((p + half) / 2^24), then clamp to the wheel range
	function automatic logic signed [WHEEL_W-1:0] round_sat(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W-1:0] r;
		r = (p + PROD_W'(ROUND_HALF)) >>> ROUND_SHIFT;
		if (r > PROD_W'(WHEEL_MAX)) begin
			return WHEEL_MAX;
		end else if (r < PROD_W'(WHEEL_MIN)) begin
			return WHEEL_MIN;
		end
		return r[WHEEL_W-1:0];
	endfunction

	assign en_s6    = !valid_s6 || out_ready;
	assign en_s5    = !valid_s5 || en_s6;
	assign en_s4    = !valid_s4 || en_s5;
	assign in_ready = en_s4;

	assign diff_v = in_data.vx - in_data.vy;
	assign plus_v = in_data.vx + in_data.vy;
	assign rot_v  = SUM_W'(in_data.rot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s4) begin
				valid_s4 <= in_valid;
			end
			if (en_s5) begin
				valid_s5 <= valid_s4;
			end
			if (en_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sum_s4[0] <= diff_v - rot_v;
			sum_s4[1] <= plus_v + rot_v;
			sum_s4[2] <= diff_v + rot_v;
			sum_s4[3] <= plus_v - rot_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int i = 0; i < 4; i++) begin
				prod_s5[i] <= sum_s4[i] * $signed({1'b0, inv_radius});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			wheels_s6.fl <= round_sat(prod_s5[0]);
			wheels_s6.fr <= round_sat(prod_s5[1]);
			wheels_s6.rl <= round_sat(prod_s5[2]);
			wheels_s6.rr <= round_sat(prod_s5[3]);
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = wheels_s6;

endmodule

// ===== rtl/core/mecanum_world_velocity_to_wheels.sv =====
// top level: mecanum inverse kinematics from a world-frame command
//
// channel  direction  handshake              payload
// cmd      in         in_valid / in_ready    yaw_rate, vel_x_world, vel_y_world, heading
// wheels   out        out_valid / out_ready  wheel_front_left/right, wheel_rear_left/right
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// six register stages: rom read, rotation multiplies, body velocity, wheel sums,
// radius multiply, round and saturate; one beat per cycle while the output is not stalled.
// the two sine rom read ports and the two multiplier stages set the stage split.
// reset clears the stage valid bits and loads the register defaults.
// a stalled output holds each stage that is full; empty stages keep filling.
// cfg_ready is always high.
module mecanum_world_velocity_to_wheels (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [mwvw_pkg::VEL_W-1:0]      yaw_rate,
	input  logic signed [mwvw_pkg::VEL_W-1:0]      vel_x_world,
	input  logic signed [mwvw_pkg::VEL_W-1:0]      vel_y_world,
	input  logic [mwvw_pkg::HEADING_W-1:0]         heading,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mwvw_pkg::WHEEL_W-1:0]    wheel_front_left,
	output logic signed [mwvw_pkg::WHEEL_W-1:0]    wheel_front_right,
	output logic signed [mwvw_pkg::WHEEL_W-1:0]    wheel_rear_left,
	output logic signed [mwvw_pkg::WHEEL_W-1:0]    wheel_rear_right,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mwvw_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [mwvw_pkg::CFG_W-1:0]             cfg_data
);
	import mwvw_pkg::*;

	logic [CFG_W-1:0] inv_radius_q;
	logic [CFG_W-1:0] lever_arm_q;

	logic    trig_valid;
	logic    trig_ready;
	trig_t   trig_data;
	logic    body_valid;
	logic    body_ready;
	body_t   body_data;
	wheels_t wheels_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_radius_q <= INV_RADIUS_RESET;
			lever_arm_q  <= LEVER_ARM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INV_RADIUS: inv_radius_q <= cfg_data;
				REG_LEVER_ARM:  lever_arm_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	mwvw_trig u_trig (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.yaw_rate    (yaw_rate),
		.vel_x_world (vel_x_world),
		.vel_y_world (vel_y_world),
		.heading     (heading),
		.out_valid   (trig_valid),
		.out_ready   (trig_ready),
		.out_data    (trig_data)
	);

	mwvw_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.lever_arm (lever_arm_q),
		.in_valid  (trig_valid),
		.in_ready  (trig_ready),
		.in_data   (trig_data),
		.out_valid (body_valid),
		.out_ready (body_ready),
		.out_data  (body_data)
	);

	mwvw_wheel u_wheel (
		.clk        (clk),
		.arst_n     (arst_n),
		.inv_radius (inv_radius_q),
		.in_valid   (body_valid),
		.in_ready   (body_ready),
		.in_data    (body_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (wheels_data)
	);

	assign wheel_front_left  = wheels_data.fl;
	assign wheel_front_right = wheels_data.fr;
	assign wheel_rear_left   = wheels_data.rl;
	assign wheel_rear_right  = wheels_data.rr;

	// an output that can move means every stage can move
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output path is free");

	// with the output drained while it passes, an accepted beat comes out of the last stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
		##1 out_ready ##1 out_ready |=> out_valid)
		else $error("beat lost in pipeline");

	a_cfg_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_INV_RADIUS)
		|=> inv_radius_q == $past(cfg_data))
		else $error("inverse radius write not taken");

	a_cfg_lever: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_LEVER_ARM)
		|=> lever_arm_q == $past(cfg_data))
		else $error("lever arm write not taken");

endmodule

// ===== test/tb_mecanum_world_velocity_to_wheels.sv =====
// testbench for the mecanum wheel speed block: directed and random commands checked against a local predictor
module tb_mecanum_world_velocity_to_wheels;

	localparam int SINE_BITS = mwvw_pkg::SINE_TABLE_BITS;
	localparam int LUT_N = 1 << SINE_BITS;
	localparam int CYCLE_LIMIT = 300000;
	localparam logic [15:0] INV_RADIUS_DEFAULT = 16'd5120;
	localparam logic [15:0] LEVER_ARM_DEFAULT = 16'd14408;
	localparam longint SPEED_HI = 64'sd8388607;
	localparam longint SPEED_LO = -64'sd8388608;

	typedef struct packed {
		logic signed [mwvw_pkg::VEL_W-1:0] yaw;
		logic signed [mwvw_pkg::VEL_W-1:0] dx;
		logic signed [mwvw_pkg::VEL_W-1:0] dy;
		logic [mwvw_pkg::HEADING_W-1:0] heading;
	} command_t;

	typedef struct packed {
		logic [mwvw_pkg::CFG_INDEX_W-1:0] addr;
		logic [mwvw_pkg::CFG_W-1:0] wdata;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [mwvw_pkg::VEL_W-1:0] yaw_rate = '0;
	logic signed [mwvw_pkg::VEL_W-1:0] vel_x_world = '0;
	logic signed [mwvw_pkg::VEL_W-1:0] vel_y_world = '0;
	logic [mwvw_pkg::HEADING_W-1:0] heading = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [mwvw_pkg::WHEEL_W-1:0] wheel_front_left;
	logic signed [mwvw_pkg::WHEEL_W-1:0] wheel_front_right;
	logic signed [mwvw_pkg::WHEEL_W-1:0] wheel_rear_left;
	logic signed [mwvw_pkg::WHEEL_W-1:0] wheel_rear_right;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [mwvw_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [mwvw_pkg::CFG_W-1:0] cfg_data = '0;

	command_t command_q[$];
	reg_write_t reg_write_q[$];
	mwvw_pkg::wheels_t want_q[$];

	longint quarter_sine [0:LUT_N];
	longint inv_radius_now = INV_RADIUS_DEFAULT;
	longint lever_arm_now = LEVER_ARM_DEFAULT;

	bit idle_on = 1'b1;
	int cmd_gap = 0;
	int stall_left = 0;
	int cycle_cnt = 0;
	int mismatch_cnt = 0;
	int commands_sent = 0;
	int regs_written = 0;
	int wheels_checked = 0;
	mwvw_pkg::wheels_t want;
	longint got_w [4];
	longint want_w [4];
	string wheel_name [4] = '{"front_left", "front_right", "rear_left", "rear_right"};

	mecanum_world_velocity_to_wheels i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.yaw_rate          (yaw_rate),
		.vel_x_world       (vel_x_world),
		.vel_y_world       (vel_y_world),
		.heading           (heading),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.wheel_front_left  (wheel_front_left),
		.wheel_front_right (wheel_front_right),
		.wheel_rear_left   (wheel_rear_left),
		.wheel_rear_right  (wheel_rear_right),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// signed sine of a heading from the quarter-wave table
	function automatic longint sine_at(logic [15:0] h);
		int unsigned idx;
		longint v;
		idx = h[13:0] >> (14 - SINE_BITS);
		v = h[14] ? quarter_sine[LUT_N - idx] : quarter_sine[idx];
		return h[15] ? -v : v;
	endfunction

	// q.28 wheel sum times inverse radius, rounded half up to q.12 and clamped
	function automatic logic signed [23:0] round_wheel(longint acc);
		longint p;
		p = (acc * inv_radius_now + 64'sd8388608) >>> 24;
		if (p > SPEED_HI) begin
			p = SPEED_HI;
		end
		if (p < SPEED_LO) begin
			p = SPEED_LO;
		end
		return p[23:0];
	endfunction

	function automatic mwvw_pkg::wheels_t wheels_for_command(command_t c);
		longint s, k, dx, dy, vx, vy, rot;
		mwvw_pkg::wheels_t w;
		s = sine_at(c.heading);
		k = sine_at(c.heading + 16'h4000);
		dx = c.dx;
		dy = c.dy;
		vx = (dx * k + dy * s) * 4;
		vy = (dy * k - dx * s) * 4;
		rot = longint'(c.yaw) * lever_arm_now;
		w.fl = round_wheel(vx - vy - rot);
		w.fr = round_wheel(rot + vx + vy);
		w.rl = round_wheel(rot + vx - vy);
		w.rr = round_wheel(vx + vy - rot);
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				want_q.insert(want_q.size(), wheels_for_command(command_q.pop_front()));
				commands_sent++;
			end
			if (!(in_valid && !in_ready)) begin
				if (cmd_gap > 0) begin
					cmd_gap--;
					in_valid <= 1'b0;
				end else if (command_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					cmd_gap = $urandom_range(1, 11) - 1;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					{yaw_rate, vel_x_world, vel_y_world, heading} <= command_q[0];
				end
			end
		end
	end

	// register write driver, keeps the local copy of the registers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mwvw_pkg::REG_INV_RADIUS) begin
					inv_radius_now = cfg_data;
				end else if (cfg_index == mwvw_pkg::REG_LEVER_ARM) begin
					lever_arm_now = cfg_data;
				end
				void'(reg_write_q.pop_front());
				regs_written++;
			end
			if (!(cfg_valid && !cfg_ready)) begin
				if (reg_write_q.size() != 0) begin
					cfg_valid <= 1'b1;
					{cfg_index, cfg_data} <= reg_write_q[0];
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// wheel speed monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got_w[0] = wheel_front_left;
				got_w[1] = wheel_front_right;
				got_w[2] = wheel_rear_left;
				got_w[3] = wheel_rear_right;
				if (want_q.size() == 0) begin
					report_mismatch($sformatf("wheel beat with nothing expected: %0d %0d %0d %0d",
						got_w[0], got_w[1], got_w[2], got_w[3]));
				end else begin
					want = want_q.pop_front();
					want_w[0] = want.fl;
					want_w[1] = want.fr;
					want_w[2] = want.rl;
					want_w[3] = want.rr;
					for (int i = 0; i < 4; i++) begin
						if (got_w[i] != want_w[i]) begin
							report_mismatch($sformatf("%s expected %0d got %0d",
								wheel_name[i], want_w[i], got_w[i]));
						end
					end
					wheels_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				want_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic push_cmd(logic [15:0] y, logic [15:0] x, logic [15:0] v, logic [15:0] h);
		command_q.insert(command_q.size(), {y, x, v, h});
	endtask

	// edges of every field, quadrant boundaries, truncated heading bits, saturating corners
	task automatic queue_directed();
		push_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		push_cmd(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
		push_cmd(16'h8000, 16'h0000, 16'h0000, 16'h0000);
		push_cmd(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
		push_cmd(16'h0000, 16'h8000, 16'h0000, 16'h0000);
		push_cmd(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
		push_cmd(16'h0000, 16'h0000, 16'h8000, 16'h0000);
		push_cmd(16'h0000, 16'h1000, 16'h0000, 16'h4000);
		push_cmd(16'h0000, 16'h1000, 16'h0000, 16'h8000);
		push_cmd(16'h0000, 16'h1000, 16'h0000, 16'hC000);
		push_cmd(16'h0000, 16'h1000, 16'h1000, 16'hFFFF);
		push_cmd(16'h0000, 16'h1000, 16'h1000, 16'h3FFF);
		push_cmd(16'h0000, 16'h1000, 16'h0000, 16'h000F);
		push_cmd(16'h0000, 16'h1000, 16'h0000, 16'h2000);
		push_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000);
		push_cmd(16'h8000, 16'h8000, 16'h8000, 16'h2000);
		push_cmd(16'h7FFF, 16'h7FFF, 16'h8000, 16'hE000);
		push_cmd(16'h8000, 16'h7FFF, 16'h8000, 16'h6000);
		push_cmd(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001);
		push_cmd(16'h1000, 16'h1000, 16'h1000, 16'hA5A5);
		push_cmd(16'h8000, 16'h8000, 16'h8000, 16'h0000);
		push_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
	endtask

	function automatic logic [15:0] pick_velocity();
		case ($urandom_range(0, 11))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_heading();
		case ($urandom_range(0, 9))
			0: return {2'($urandom), 14'h0000};
			1: return {2'($urandom), 14'h3FFF};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			push_cmd(pick_velocity(), pick_velocity(), pick_velocity(), pick_heading());
		end
	endtask

	// wait for every command to come back, then let the pipeline settle
	task automatic drain();
		while (command_q.size() != 0 || in_valid || want_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] inv_radius, logic [15:0] lever);
		reg_write_q.insert(reg_write_q.size(), {mwvw_pkg::REG_INV_RADIUS, inv_radius});
		reg_write_q.insert(reg_write_q.size(), {mwvw_pkg::REG_LEVER_ARM, lever});
		while (reg_write_q.size() != 0 || cfg_valid) begin
			@(posedge clk);
		end
	endtask

	initial begin
		longint unsigned kk, ang, ang2, term;
		longint acc;
		for (kk = 0; kk <= LUT_N; kk++) begin
			ang = (kk * 64'd1686629713) >> SINE_BITS;
			ang2 = (ang * ang) >> 30;
			term = ang;
			acc = longint'(ang);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
				acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) begin
				acc = 0;
			end
			acc = (acc + 32768) >>> 16;
			quarter_sine[kk] = (acc > 16384) ? 64'sd16384 : acc;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// registers at their reset values
		queue_directed();
		queue_random(180);
		drain();

		// largest inverse radius and lever arm drive the outputs into saturation
		write_regs(16'hFFFF, 16'hFFFF);
		queue_directed();
		queue_random(180);
		drain();

		// zero inverse radius, with writes to unknown indexes that must be ignored
		reg_write_q.insert(reg_write_q.size(), {8'd2, 16'hFFFF});
		reg_write_q.insert(reg_write_q.size(), {8'hFF, 16'h5A5A});
		write_regs(16'h0000, 16'h0000);
		queue_directed();
		queue_random(150);
		drain();

		idle_on = 1'b0;
		write_regs(16'h0001, 16'hFFFF);
		queue_random(150);
		drain();

		idle_on = 1'b1;
		repeat (3) begin
			write_regs(16'($urandom), 16'($urandom));
			queue_random(150);
			drain();
		end

		// back to defaults, no idling on either side
		idle_on = 1'b0;
		reg_write_q.insert(reg_write_q.size(), {8'd3, 16'h0000});
		write_regs(INV_RADIUS_DEFAULT, LEVER_ARM_DEFAULT);
		queue_random(200);
		drain();

		$display("sent %0d commands over 8 register settings, %0d register writes",
			commands_sent, regs_written);
		$display("checked %0d wheel results, %0d mismatches", wheels_checked, mismatch_cnt);
		if (mismatch_cnt == 0 && want_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mwvw_pkg.sv
rtl/core/mwvw_trig.sv
rtl/core/mwvw_rotate.sv
rtl/core/mwvw_wheel.sv
rtl/core/mecanum_world_velocity_to_wheels.sv
test/tb_mecanum_world_velocity_to_wheels.sv
